FILE: sv/dbba_pkg.sv
// ----------------------------------------------------------------------------
// dbba_pkg
// Shared geometry, widths, status codes and field helpers for the disk block
// bitmap allocator.
// ----------------------------------------------------------------------------
package dbba_pkg;

  // Disk geometry
  localparam int NUM_CYLINDERS       = 8;
  localparam int RECORDS_PER_TRACK   = 4;
  localparam int TRACKS_PER_CYLINDER = 2;
  localparam int BITS_PER_ROW        = TRACKS_PER_CYLINDER * RECORDS_PER_TRACK;
  localparam int NUM_BLOCKS          = NUM_CYLINDERS * BITS_PER_ROW;
  localparam int MAX_GRANT           = 64;

  // Fixed field widths
  localparam int FUNC_W   = 1;
  localparam int COUNT_W  = 7;
  localparam int CYL_W    = 3;
  localparam int TRACK_W  = 1;
  localparam int RECORD_W = 2;
  localparam int STATUS_W = 2;

  // Internal widths derived from geometry
  localparam int CI_W  = (NUM_CYLINDERS > 1) ? $clog2(NUM_CYLINDERS) : 1;
  localparam int BI_W  = (BITS_PER_ROW > 1) ? $clog2(BITS_PER_ROW) : 1;
  localparam int FC_W  = $clog2(NUM_BLOCKS + 1);
  localparam int CMP_W = (FC_W > COUNT_W) ? FC_W : COUNT_W;

  // Request codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_GRANT  = 2'd0,
    ST_REFUSE = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FREED  = 2'd3
  } status_t;

  // Cylinder index to output field, masked to the field width
  function automatic logic [CYL_W-1:0] cyl_field(input logic [CI_W-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[CYL_W-1:0];
  endfunction

  // Bit position within a row to track field
  function automatic logic [TRACK_W-1:0] track_field(input logic [BI_W-1:0] b);
    logic [31:0] w;
    w = 32'(b) / RECORDS_PER_TRACK;
    return w[TRACK_W-1:0];
  endfunction

  // Bit position within a row to record field
  function automatic logic [RECORD_W-1:0] record_field(input logic [BI_W-1:0] b);
    logic [31:0] w;
    w = 32'(b) % RECORDS_PER_TRACK;
    return w[RECORD_W-1:0];
  endfunction

endpackage

FILE: sv/disk_block_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// disk_block_bitmap_allocator
// First-fit allocator over a bit map of disk blocks, one row per cylinder,
// with one result per granted block, or one result for a free, empty or refused request.
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------
//  in       | in_valid / in_stall     | func, request_count, cyl_in, track_in,
//           |                         | record_in
//  out      | out_valid / out_stall   | status, cyl_out, track_out, record_out,
//           |                         | last
//
//  A free or empty request is accepted in S_IDLE and its result is loaded
//  from S_SINGLE. An allocate request walks the map one bit a cycle on the
//  scan position shared by both walks: S_COUNT counts the free ones of all
//  NUM_BLOCKS (64) bits, S_CHECK decides, S_GRANT marks and emits grants.
//  A stalled output freezes the grant walk; the input is stalled until the
//  current transaction has loaded its last result into the output register.
//  Synchronous reset clears the map (every block free) and the control state.
//
module disk_block_bitmap_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [dbba_pkg::FUNC_W-1:0]    func,
  input  logic [dbba_pkg::COUNT_W-1:0]   request_count,
  input  logic [dbba_pkg::CYL_W-1:0]     cyl_in,
  input  logic [dbba_pkg::TRACK_W-1:0]   track_in,
  input  logic [dbba_pkg::RECORD_W-1:0]  record_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [dbba_pkg::STATUS_W-1:0]  status,
  output logic [dbba_pkg::CYL_W-1:0]     cyl_out,
  output logic [dbba_pkg::TRACK_W-1:0]   track_out,
  output logic [dbba_pkg::RECORD_W-1:0]  record_out,
  output logic                           last
);
  import dbba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SINGLE,
    S_COUNT,
    S_CHECK,
    S_GRANT
  } state_t;

  state_t                              state;
  logic [NUM_CYLINDERS-1:0][BITS_PER_ROW-1:0] used_map;

  // Scan position and shared counters
  logic [CI_W-1:0]     scan_cyl;
  logic [BI_W-1:0]     scan_bit;
  logic [FC_W-1:0]     free_count;
  logic [COUNT_W-1:0]  want;
  logic [COUNT_W-1:0]  granted;

  // Pending single result
  logic [STATUS_W-1:0] pend_status;
  logic [CYL_W-1:0]    pend_cyl;
  logic [TRACK_W-1:0]  pend_trk;
  logic [RECORD_W-1:0] pend_rec;

  logic                in_accept;
  logic                out_free;
  logic                out_load;
  logic                scan_end;
  logic                bit_used;
  logic                free_in_range;
  logic [CI_W-1:0]     free_cyl;
  logic [BI_W-1:0]     free_bit;
  logic [COUNT_W-1:0]  granted_next;
  logic [CMP_W-1:0]    want_ext;
  logic [CMP_W-1:0]    count_ext;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Current scan bit and end of walk
  assign bit_used = used_map[scan_cyl][scan_bit];
  assign scan_end = (32'(scan_cyl) == NUM_CYLINDERS - 1) &&
                    (32'(scan_bit) == BITS_PER_ROW - 1);

  // Output register takes a new transaction this cycle
  assign out_load = out_free &&
                    ((state == S_SINGLE) || ((state == S_GRANT) && !bit_used));

  // Address of a block to free
  assign free_in_range = (32'(cyl_in) < NUM_CYLINDERS) &&
                         (32'(record_in) < RECORDS_PER_TRACK);
  assign free_cyl      = CI_W'(cyl_in);
  assign free_bit      = BI_W'(32'(track_in) * RECORDS_PER_TRACK + 32'(record_in));

  assign granted_next = granted + COUNT_W'(1);
  assign want_ext     = CMP_W'(want);
  assign count_ext    = CMP_W'(free_count);

  // Sequencer, map and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used_map  <= '0;
      out_valid <= 1'b0;
    end else begin
      // Load a new transaction, or drop the one just taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            want <= request_count;
            if (func == FUNC_FREE) begin
              if (free_in_range) begin
                used_map[free_cyl][free_bit] <= 1'b0;
              end
              pend_status <= ST_FREED;
              pend_cyl    <= cyl_in;
              pend_trk    <= track_in;
              pend_rec    <= record_in;
              state       <= S_SINGLE;
            end else if (request_count == '0) begin
              pend_status <= ST_EMPTY;
              pend_cyl    <= '0;
              pend_trk    <= '0;
              pend_rec    <= '0;
              state       <= S_SINGLE;
            end else begin
              scan_cyl   <= '0;
              scan_bit   <= '0;
              free_count <= '0;
              state      <= S_COUNT;
            end
          end
        end

        // Emit the one result of a free, empty or refused request
        S_SINGLE: begin
          if (out_free) begin
            status     <= pend_status;
            cyl_out    <= pend_cyl;
            track_out  <= pend_trk;
            record_out <= pend_rec;
            last       <= 1'b1;
            state      <= S_IDLE;
          end
        end

        // Count free blocks, one bit a cycle
        S_COUNT: begin
          if (!bit_used) begin
            free_count <= free_count + FC_W'(1);
          end
          if (scan_end) begin
            state <= S_CHECK;
          end else if (32'(scan_bit) == BITS_PER_ROW - 1) begin
            scan_bit <= '0;
            scan_cyl <= scan_cyl + CI_W'(1);
          end else begin
            scan_bit <= scan_bit + BI_W'(1);
          end
        end

        // Refuse, or restart the walk to grant
        S_CHECK: begin
          if ((32'(want) > MAX_GRANT) || (want_ext > count_ext)) begin
            pend_status <= ST_REFUSE;
            pend_cyl    <= '0;
            pend_trk    <= '0;
            pend_rec    <= '0;
            state       <= S_SINGLE;
          end else begin
            scan_cyl <= '0;
            scan_bit <= '0;
            granted  <= '0;
            state    <= S_GRANT;
          end
        end

        // Mark and emit free blocks in scan order; hold on a stalled output
        S_GRANT: begin
          if (!bit_used && !out_free) begin
            state <= S_GRANT;
          end else begin
            if (!bit_used) begin
              used_map[scan_cyl][scan_bit] <= 1'b1;
              status     <= ST_GRANT;
              cyl_out    <= cyl_field(scan_cyl);
              track_out  <= track_field(scan_bit);
              record_out <= record_field(scan_bit);
              last       <= (granted_next == want);
              granted    <= granted_next;
            end
            if ((!bit_used && granted_next == want) || scan_end) begin
              state <= S_IDLE;
            end else if (32'(scan_bit) == BITS_PER_ROW - 1) begin
              scan_bit <= '0;
              scan_cyl <= scan_cyl + CI_W'(1);
            end else begin
              scan_bit <= scan_bit + BI_W'(1);
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
